### hw/rtl/lcss_pkg.sv
// shared types and codes for the trajectory lcss matcher
package lcss_pkg;

  localparam int COORD_W = 32;
  localparam int THR_W   = 31;
  localparam int LEN_W   = 6;
  localparam int IDX_W   = 5;

  localparam logic [1:0] ACT_APPEND_P = 2'd0;
  localparam logic [1:0] ACT_APPEND_Q = 2'd1;
  localparam logic [1:0] ACT_COMPUTE  = 2'd2;

  typedef enum logic [1:0] {
    DIR_DIAG = 2'd0,
    DIR_LEFT = 2'd1,
    DIR_UP   = 2'd2
  } lcss_dir_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_DRAIN,
    ST_TB_ISSUE,
    ST_TB_EVAL
  } lcss_state_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } lcss_point_t;

  typedef struct packed {
    logic [1:0]                action;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
  } lcss_req_t;

  typedef struct packed {
    logic                      is_match;
    logic [LEN_W-1:0]          common_length;
    logic [IDX_W-1:0]          p_index;
    logic [IDX_W-1:0]          q_index;
    logic signed [COORD_W-1:0] p_x;
    logic signed [COORD_W-1:0] p_y;
    logic signed [COORD_W-1:0] q_x;
    logic signed [COORD_W-1:0] q_y;
    logic                      last;
  } lcss_res_t;

  // control travelling alongside a cell through the distance pipeline
  typedef struct packed {
    logic vld;
    logic bnd;
    logic fin;
  } lcss_ctl_t;

endpackage

### hw/rtl/lcss_ram.sv
// generic single write port ram with registered read
module lcss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/lcss_dist.sv
// pipelined squared distance compare of two points against the threshold
module lcss_dist
  import lcss_pkg::*;
(
  input  logic               clk_i,
  input  lcss_point_t        p_i,
  input  lcss_point_t        q_i,
  input  logic [THR_W-1:0]   thr_i,
  output logic               match_o
);

  logic [COORD_W:0]       dx_s, dy_s;
  logic [COORD_W-1:0]     dx_d, dy_d, dx_q, dy_q;
  logic [2*COORD_W-1:0]   sx_q, sy_q;
  logic [2*THR_W-1:0]     tsq_q;
  logic [2*COORD_W:0]     sum;

  always_comb begin
    dx_s = {p_i.x[COORD_W-1], p_i.x} - {q_i.x[COORD_W-1], q_i.x};
    dy_s = {p_i.y[COORD_W-1], p_i.y} - {q_i.y[COORD_W-1], q_i.y};
    dx_d = dx_s[COORD_W] ? COORD_W'(~dx_s + 1'b1) : dx_s[COORD_W-1:0];
    dy_d = dy_s[COORD_W] ? COORD_W'(~dy_s + 1'b1) : dy_s[COORD_W-1:0];
    sum  = {1'b0, sx_q} + {1'b0, sy_q};
  end

  always_ff @(posedge clk_i) begin
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    sx_q    <= dx_q * dx_q;
    sy_q    <= dy_q * dy_q;
    tsq_q   <= thr_i * thr_i;
    match_o <= (sum <= (2*COORD_W+1)'(tsq_q));
  end

endmodule

### hw/rtl/lcss_row.sv
// chain of row cells holding the previous table row and the cell recurrence
module lcss_row
  import lcss_pkg::*;
#(
  parameter int TD = 33,
  parameter int LW = 6
) (
  input  logic          clk_i,
  input  logic          shift_i,
  input  logic          bnd_i,
  input  logic          match_i,
  output logic [LW-1:0] len_o,
  output lcss_dir_e     dir_o
);

  // cell 0 is the left neighbour, cell TD-1 the one above, cell TD the diagonal
  logic [LW-1:0] cell_q [TD+1];
  logic [LW-1:0] left, up, diag;

  assign left = cell_q[0];
  assign up   = cell_q[TD-1];
  assign diag = cell_q[TD];

  always_comb begin
    if (bnd_i) begin
      len_o = '0;
      dir_o = DIR_UP;
    end else if (match_i) begin
      len_o = diag + 1'b1;
      dir_o = DIR_DIAG;
    end else if (left > up) begin
      len_o = left;
      dir_o = DIR_LEFT;
    end else begin
      len_o = up;
      dir_o = DIR_UP;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      cell_q[0] <= len_o;
      for (int k = 1; k <= TD; k++) begin
        cell_q[k] <= cell_q[k-1];
      end
    end
  end

endmodule

### hw/rtl/trajectory_lcss_match_core.sv
// an append stores its point and bumps its count when accepted; a compute sweeps (p_count+1)*(MAX_POINTS+1) cells
// at one cell per cycle through the row chain, then the distance pipeline drains,
// then a traceback runs, each step a table ram read followed by an evaluation
// results leave as strobes; the receiver cannot stall them
// reset clears the point counts and threshold; point and table rams are not cleared
module trajectory_lcss_match_core
  import lcss_pkg::*;
#(
  parameter int MAX_POINTS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  lcss_req_t        req_i,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [THR_W-1:0] cfg_data_i,
  output logic             result_valid_o,
  output lcss_res_t        res_o
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int PAW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int TD    = MAX_POINTS + 1;
  localparam int TAW   = $clog2(TD * TD);
  localparam int TBL_W = CNT_W + 2;

  lcss_state_e state_q, state_d;
  logic [THR_W-1:0] thr_q;
  logic [CNT_W-1:0] pcnt_q, pcnt_d, qcnt_q, qcnt_d;
  logic [CNT_W-1:0] fi_q, fi_d, fj_q, fj_d;
  logic [CNT_W-1:0] ti_q, ti_d, tj_q, tj_d, k_q, k_d, len_q, len_d;
  logic [TAW-1:0]   waddr_q, waddr_d, taddr_q, taddr_d;
  logic             first_q, first_d;
  lcss_ctl_t        pipe_q [4];
  lcss_ctl_t        issue;
  lcss_res_t        res_d;
  logic             res_valid_d;

  logic             accept;
  logic             p_we, q_we;
  logic [PAW-1:0]   p_raddr, q_raddr;
  logic [2*COORD_W-1:0] p_rdata, q_rdata;
  lcss_point_t      p_pt, q_pt, new_pt;
  logic             match;
  logic [CNT_W-1:0] dp_len;
  lcss_dir_e        dp_dir;
  logic [TBL_W-1:0] tbl_rdata;
  logic [CNT_W-1:0] tb_len, cur_len;
  lcss_dir_e        tb_dir;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign new_pt      = '{y: req_i.coord_y, x: req_i.coord_x};
  assign p_pt        = lcss_point_t'(p_rdata);
  assign q_pt        = lcss_point_t'(q_rdata);
  assign tb_len      = tbl_rdata[CNT_W-1:0];
  assign tb_dir      = lcss_dir_e'(tbl_rdata[TBL_W-1:CNT_W]);
  assign cur_len     = first_q ? tb_len : len_q;

  assign p_we = accept && (req_i.action == ACT_APPEND_P) && (pcnt_q < CNT_W'(MAX_POINTS));
  assign q_we = accept && (req_i.action == ACT_APPEND_Q) && (qcnt_q < CNT_W'(MAX_POINTS));

  always_comb begin
    if (state_q == ST_FILL) begin
      p_raddr = PAW'(fi_q - 1'b1);
      q_raddr = PAW'(fj_q - 1'b1);
    end else begin
      p_raddr = PAW'(ti_q - 1'b1);
      q_raddr = PAW'(tj_q - 1'b1);
    end
  end

  lcss_ram #(.WIDTH(2*COORD_W), .DEPTH(MAX_POINTS)) u_p_ram (
    .clk_i  (clk_i),
    .we_i   (p_we),
    .waddr_i(PAW'(pcnt_q)),
    .wdata_i(new_pt),
    .raddr_i(p_raddr),
    .rdata_o(p_rdata)
  );

  lcss_ram #(.WIDTH(2*COORD_W), .DEPTH(MAX_POINTS)) u_q_ram (
    .clk_i  (clk_i),
    .we_i   (q_we),
    .waddr_i(PAW'(qcnt_q)),
    .wdata_i(new_pt),
    .raddr_i(q_raddr),
    .rdata_o(q_rdata)
  );

  lcss_dist u_dist (
    .clk_i  (clk_i),
    .p_i    (p_pt),
    .q_i    (q_pt),
    .thr_i  (thr_q),
    .match_o(match)
  );

  lcss_row #(.TD(TD), .LW(CNT_W)) u_row (
    .clk_i  (clk_i),
    .shift_i(pipe_q[3].vld),
    .bnd_i  (pipe_q[3].bnd),
    .match_i(match),
    .len_o  (dp_len),
    .dir_o  (dp_dir)
  );

  lcss_ram #(.WIDTH(TBL_W), .DEPTH(TD*TD)) u_tbl_ram (
    .clk_i  (clk_i),
    .we_i   (pipe_q[3].vld),
    .waddr_i(waddr_q),
    .wdata_i({dp_dir, dp_len}),
    .raddr_i(taddr_q),
    .rdata_o(tbl_rdata)
  );

  // cell issue during the fill sweep
  always_comb begin
    issue.vld = (state_q == ST_FILL);
    issue.bnd = (fi_q == '0) || (fj_q == '0) || (fj_q > qcnt_q);
    issue.fin = (fi_q == pcnt_q) && (fj_q == CNT_W'(MAX_POINTS));
  end

  always_comb begin
    state_d     = state_q;
    pcnt_d      = pcnt_q;
    qcnt_d      = qcnt_q;
    fi_d        = fi_q;
    fj_d        = fj_q;
    ti_d        = ti_q;
    tj_d        = tj_q;
    k_d         = k_q;
    len_d       = len_q;
    taddr_d     = taddr_q;
    first_d     = first_q;
    waddr_d     = pipe_q[3].vld ? waddr_q + 1'b1 : waddr_q;
    res_d       = '0;
    res_valid_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (p_we) pcnt_d = pcnt_q + 1'b1;
        if (q_we) qcnt_d = qcnt_q + 1'b1;
        if (accept && req_i.action == ACT_COMPUTE) begin
          fi_d    = '0;
          fj_d    = '0;
          waddr_d = '0;
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        if (fj_q == CNT_W'(MAX_POINTS)) begin
          fj_d = '0;
          fi_d = fi_q + 1'b1;
        end else begin
          fj_d = fj_q + 1'b1;
        end
        if (issue.fin) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (pipe_q[3].vld && pipe_q[3].fin) begin
          ti_d    = pcnt_q;
          tj_d    = qcnt_q;
          taddr_d = TAW'(pcnt_q * TD) + TAW'(qcnt_q);
          k_d     = '0;
          first_d = 1'b1;
          state_d = ST_TB_ISSUE;
        end
      end
      ST_TB_ISSUE: begin
        if (ti_q == '0 || tj_q == '0) begin
          if (first_q) begin
            res_valid_d = 1'b1;
            res_d.last  = 1'b1;
          end
          state_d = ST_IDLE;
        end else begin
          state_d = ST_TB_EVAL;
        end
      end
      ST_TB_EVAL: begin
        first_d = 1'b0;
        if (first_q) len_d = tb_len;
        state_d = ST_TB_ISSUE;
        if (tb_len == '0) begin
          if (first_q) begin
            res_valid_d = 1'b1;
            res_d.last  = 1'b1;
          end
          state_d = ST_IDLE;
        end else begin
          case (tb_dir)
            DIR_LEFT: begin
              tj_d    = tj_q - 1'b1;
              taddr_d = taddr_q - 1'b1;
            end
            DIR_UP: begin
              ti_d    = ti_q - 1'b1;
              taddr_d = taddr_q - TAW'(TD);
            end
            default: begin
              res_valid_d         = 1'b1;
              res_d.is_match      = 1'b1;
              res_d.common_length = LEN_W'(cur_len);
              res_d.p_index       = IDX_W'(ti_q - 1'b1);
              res_d.q_index       = IDX_W'(tj_q - 1'b1);
              res_d.p_x           = p_pt.x;
              res_d.p_y           = p_pt.y;
              res_d.q_x           = q_pt.x;
              res_d.q_y           = q_pt.y;
              res_d.last          = ({1'b0, k_q} + 1'b1) == {1'b0, cur_len};
              k_d                 = k_q + 1'b1;
              ti_d                = ti_q - 1'b1;
              tj_d                = tj_q - 1'b1;
              taddr_d             = taddr_q - TAW'(TD + 1);
            end
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      thr_q          <= '0;
      pcnt_q         <= '0;
      qcnt_q         <= '0;
      result_valid_o <= 1'b0;
      for (int s = 0; s < 4; s++) begin
        pipe_q[s] <= '0;
      end
    end else begin
      state_q        <= state_d;
      pcnt_q         <= pcnt_d;
      qcnt_q         <= qcnt_d;
      result_valid_o <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) thr_q <= cfg_data_i;
      pipe_q[0] <= issue;
      for (int s = 1; s < 4; s++) begin
        pipe_q[s] <= pipe_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fi_q    <= fi_d;
    fj_q    <= fj_d;
    ti_q    <= ti_d;
    tj_q    <= tj_d;
    k_q     <= k_d;
    len_q   <= len_d;
    taddr_q <= taddr_d;
    waddr_q <= waddr_d;
    first_q <= first_d;
    res_o   <= res_d;
  end

  a_compute_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_i.action == ACT_COMPUTE |=> busy)
    else $error("compute request did not start a run");

  a_cells_only_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pipe_q[3].vld |-> (state_q == ST_FILL || state_q == ST_DRAIN))
    else $error("table cell written outside the fill sweep");

  a_match_has_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && res_o.is_match |-> res_o.common_length != '0)
    else $error("matched pair with zero common length");

  a_no_result_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && res_o.last |=> !result_valid_o)
    else $error("result follows the final one of a run");

  a_counts_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pcnt_q <= CNT_W'(MAX_POINTS) && qcnt_q <= CNT_W'(MAX_POINTS))
    else $error("point count beyond capacity");

endmodule
